// File: src/ubi_pkg.sv
// shared types, constants and tap table of the 4x block interpolator
`timescale 1ns / 1ps

package ubi_pkg;

  localparam int PIXEL_BITS  = 8;
  localparam int WEIGHT_BITS = 5;
  localparam int SUM_BITS    = PIXEL_BITS + WEIGHT_BITS;
  localparam int RECIP_BITS  = 14;
  localparam int PROD_BITS   = SUM_BITS + RECIP_BITS;
  localparam int RECIP_SHIFT = 18;
  localparam int LANES       = 4;

  // ceil(2^18 / 26), exact floor for every sum below 2^18 / 14
  localparam logic [RECIP_BITS-1:0] RECIP_26 = 14'd10083;

  localparam logic [1:0] LAST_ROW_IDX = 2'd3;

  typedef logic [PIXEL_BITS-1:0]  pixel_t;
  typedef logic [WEIGHT_BITS-1:0] weight_t;
  typedef logic [SUM_BITS-1:0]    sum_t;

  typedef enum logic [2:0] {
    DIV_1,
    DIV_2,
    DIV_4,
    DIV_26,
    DIV_32
  } div_sel_t;

  typedef struct packed {
    weight_t  wa;
    weight_t  wb;
    weight_t  wc;
    weight_t  wd;
    div_sel_t div;
  } tap_t;

  typedef struct packed {
    logic       vld;
    logic [1:0] row;
    pixel_t     a;
    pixel_t     b;
    pixel_t     c;
    pixel_t     d;
    logic       last_row;
    logic       last_col;
  } row_job_t;

  // weights of a, b, c, d and divisor for interior block position (row, col)
  function automatic tap_t tap_lookup(logic [1:0] row, logic [1:0] col);
    tap_t t;
    case ({row, col})
      4'h0:    t = '{5'd1,  5'd0,  5'd0,  5'd0,  DIV_1};
      4'h1:    t = '{5'd20, 5'd6,  5'd0,  5'd0,  DIV_26};
      4'h2:    t = '{5'd1,  5'd1,  5'd0,  5'd0,  DIV_2};
      4'h3:    t = '{5'd6,  5'd20, 5'd0,  5'd0,  DIV_26};
      4'h4:    t = '{5'd20, 5'd0,  5'd6,  5'd0,  DIV_26};
      4'h5:    t = '{5'd14, 5'd7,  5'd7,  5'd4,  DIV_32};
      4'h6:    t = '{5'd10, 5'd10, 5'd3,  5'd3,  DIV_26};
      4'h7:    t = '{5'd7,  5'd14, 5'd4,  5'd7,  DIV_32};
      4'h8:    t = '{5'd1,  5'd0,  5'd1,  5'd0,  DIV_2};
      4'h9:    t = '{5'd10, 5'd3,  5'd10, 5'd3,  DIV_26};
      4'hA:    t = '{5'd1,  5'd1,  5'd1,  5'd1,  DIV_4};
      4'hB:    t = '{5'd3,  5'd10, 5'd3,  5'd10, DIV_26};
      4'hC:    t = '{5'd6,  5'd0,  5'd20, 5'd0,  DIV_26};
      4'hD:    t = '{5'd7,  5'd4,  5'd14, 5'd7,  DIV_32};
      4'hE:    t = '{5'd3,  5'd3,  5'd10, 5'd10, DIV_26};
      4'hF:    t = '{5'd4,  5'd7,  5'd7,  5'd14, DIV_32};
      default: t = '{5'd1,  5'd0,  5'd0,  5'd0,  DIV_1};
    endcase
    return t;
  endfunction

endpackage

// File: src/ubi_in_if.sv
// input channel: one 2x2 source neighbourhood with edge flags per item
`timescale 1ns / 1ps

interface ubi_in_if;
  logic                  valid;
  logic                  ready;
  logic [ubi_pkg::PIXEL_BITS-1:0] top_left;
  logic [ubi_pkg::PIXEL_BITS-1:0] top_right;
  logic [ubi_pkg::PIXEL_BITS-1:0] bottom_left;
  logic [ubi_pkg::PIXEL_BITS-1:0] bottom_right;
  logic                  on_last_row;
  logic                  on_last_column;

  modport source (
    output valid, top_left, top_right, bottom_left, bottom_right,
           on_last_row, on_last_column,
    input  ready
  );

  modport sink (
    input  valid, top_left, top_right, bottom_left, bottom_right,
           on_last_row, on_last_column,
    output ready
  );
endinterface

// File: src/ubi_out_if.sv
// result channel: one row of the 4x4 output block per item
`timescale 1ns / 1ps

interface ubi_out_if;
  logic                  valid;
  logic                  ready;
  logic [1:0]            block_row;
  logic [ubi_pkg::PIXEL_BITS-1:0] pixel_0;
  logic [ubi_pkg::PIXEL_BITS-1:0] pixel_1;
  logic [ubi_pkg::PIXEL_BITS-1:0] pixel_2;
  logic [ubi_pkg::PIXEL_BITS-1:0] pixel_3;
  logic                  last_row_of_block;

  modport source (
    output valid, block_row, pixel_0, pixel_1, pixel_2, pixel_3, last_row_of_block,
    input  ready
  );

  modport sink (
    input  valid, block_row, pixel_0, pixel_1, pixel_2, pixel_3, last_row_of_block,
    output ready
  );
endinterface

// File: src/ubi_row_seq.sv
// row sequencer: holds one neighbourhood and issues its four row jobs
`timescale 1ns / 1ps

module ubi_row_seq (
  input  logic              clk,
  input  logic              rst_n,
  ubi_in_if.sink            in_chan,
  input  logic              advance,
  output ubi_pkg::row_job_t job
);

  logic            hold_vld_r;
  logic            hold_vld_nxt;
  logic [1:0]      row_r;
  logic [1:0]      row_nxt;
  ubi_pkg::pixel_t a_r, b_r, c_r, d_r;
  logic            last_row_r;
  logic            last_col_r;
  logic            take;
  logic            done;

  assign done           = hold_vld_r && advance && (row_r == ubi_pkg::LAST_ROW_IDX);
  assign in_chan.ready  = !hold_vld_r || done;
  assign take           = in_chan.valid && in_chan.ready;

  always_comb begin
    hold_vld_nxt = hold_vld_r;
    row_nxt      = row_r;
    if (take) begin
      hold_vld_nxt = 1'b1;
      row_nxt      = 2'd0;
    end else if (done) begin
      hold_vld_nxt = 1'b0;
    end else if (hold_vld_r && advance) begin
      row_nxt = row_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
      row_r      <= 2'd0;
    end else begin
      hold_vld_r <= hold_vld_nxt;
      row_r      <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      a_r        <= in_chan.top_left;
      b_r        <= in_chan.top_right;
      c_r        <= in_chan.bottom_left;
      d_r        <= in_chan.bottom_right;
      last_row_r <= in_chan.on_last_row;
      last_col_r <= in_chan.on_last_column;
    end
  end

  always_comb begin
    job.vld      = hold_vld_r;
    job.row      = row_r;
    job.a        = a_r;
    job.b        = b_r;
    job.c        = c_r;
    job.d        = d_r;
    job.last_row = last_row_r;
    job.last_col = last_col_r;
  end

endmodule

// File: src/ubi_row_pipe.sv
// three-stage row datapath: tap decode, weighted sum, divide and output register
`timescale 1ns / 1ps

module ubi_row_pipe (
  input  logic              clk,
  input  logic              rst_n,
  input  ubi_pkg::row_job_t job,
  output logic              advance,
  ubi_out_if.source         out_chan
);

  localparam int LANES = ubi_pkg::LANES;

  // stage 1: taps and pixels
  logic               s1_vld_r;
  logic [1:0]         s1_row_r;
  ubi_pkg::pixel_t    s1_a_r, s1_b_r, s1_c_r, s1_d_r;
  ubi_pkg::tap_t      s1_tap_r [LANES];
  ubi_pkg::tap_t      s1_tap_nxt [LANES];

  // stage 2: weighted sums
  logic               s2_vld_r;
  logic [1:0]         s2_row_r;
  ubi_pkg::sum_t      s2_sum_r [LANES];
  ubi_pkg::sum_t      s2_sum_nxt [LANES];
  ubi_pkg::div_sel_t  s2_div_r [LANES];

  // stage 3: output register
  logic               out_vld_r;
  logic [1:0]         out_row_r;
  ubi_pkg::pixel_t    out_pix_r [LANES];
  ubi_pkg::pixel_t    out_pix_nxt [LANES];

  logic [1:0]         eff_row;

  assign advance = !out_vld_r || out_chan.ready;
  assign eff_row = job.last_row ? 2'd0 : job.row;

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      s1_tap_nxt[k] = ubi_pkg::tap_lookup(eff_row, job.last_col ? 2'd0 : 2'(k));
    end
  end

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      s2_sum_nxt[k] =
          ubi_pkg::SUM_BITS'(s1_tap_r[k].wa) * ubi_pkg::SUM_BITS'(s1_a_r)
        + ubi_pkg::SUM_BITS'(s1_tap_r[k].wb) * ubi_pkg::SUM_BITS'(s1_b_r)
        + ubi_pkg::SUM_BITS'(s1_tap_r[k].wc) * ubi_pkg::SUM_BITS'(s1_c_r)
        + ubi_pkg::SUM_BITS'(s1_tap_r[k].wd) * ubi_pkg::SUM_BITS'(s1_d_r);
    end
  end

  always_comb begin
    logic [ubi_pkg::PROD_BITS-1:0] prod;
    for (int k = 0; k < LANES; k++) begin
      prod = ubi_pkg::PROD_BITS'(s2_sum_r[k]) * ubi_pkg::PROD_BITS'(ubi_pkg::RECIP_26);
      case (s2_div_r[k])
        ubi_pkg::DIV_1:  out_pix_nxt[k] = s2_sum_r[k][0 +: ubi_pkg::PIXEL_BITS];
        ubi_pkg::DIV_2:  out_pix_nxt[k] = s2_sum_r[k][1 +: ubi_pkg::PIXEL_BITS];
        ubi_pkg::DIV_4:  out_pix_nxt[k] = s2_sum_r[k][2 +: ubi_pkg::PIXEL_BITS];
        ubi_pkg::DIV_32: out_pix_nxt[k] = s2_sum_r[k][5 +: ubi_pkg::PIXEL_BITS];
        ubi_pkg::DIV_26: out_pix_nxt[k] = prod[ubi_pkg::RECIP_SHIFT +: ubi_pkg::PIXEL_BITS];
        default:         out_pix_nxt[k] = s2_sum_r[k][0 +: ubi_pkg::PIXEL_BITS];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (advance) begin
      s1_vld_r  <= job.vld;
      s2_vld_r  <= s1_vld_r;
      out_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_row_r  <= job.row;
      s1_a_r    <= job.a;
      s1_b_r    <= job.b;
      s1_c_r    <= job.c;
      s1_d_r    <= job.d;
      s2_row_r  <= s1_row_r;
      out_row_r <= s2_row_r;
      for (int k = 0; k < LANES; k++) begin
        s1_tap_r[k]  <= s1_tap_nxt[k];
        s2_sum_r[k]  <= s2_sum_nxt[k];
        s2_div_r[k]  <= s1_tap_r[k].div;
        out_pix_r[k] <= out_pix_nxt[k];
      end
    end
  end

  assign out_chan.valid             = out_vld_r;
  assign out_chan.block_row         = out_row_r;
  assign out_chan.pixel_0           = out_pix_r[0];
  assign out_chan.pixel_1           = out_pix_r[1];
  assign out_chan.pixel_2           = out_pix_r[2];
  assign out_chan.pixel_3           = out_pix_r[3];
  assign out_chan.last_row_of_block = (out_row_r == ubi_pkg::LAST_ROW_IDX);

endmodule

// File: src/upscale4x_block_interpolator_unit.sv
// top level of the 4x block interpolator
`timescale 1ns / 1ps

// Takes one 2x2 source neighbourhood (top_left, top_right, bottom_left,
// bottom_right) with last-row and last-column flags and returns the 4x4
// upscaled block as four row items, rows 0 to 3 in order, with
// last_row_of_block set on row 3. The row datapath produces one row per
// cycle while the output is ready; the next neighbourhood is taken in the
// cycle its predecessor issues its last row. The first row is presented
// from the output register, three pipeline stages behind the row holding
// register. A stalled output freezes the whole pipeline without loss.
// Sums with divisor 26 are divided exactly (floor) through a reciprocal
// multiply, the other divisors by a shift; corner cells repeat top_left.

module upscale4x_block_interpolator_unit (
  input  logic       clk,
  input  logic       rst_n,
  ubi_in_if.sink     in_chan,
  ubi_out_if.source  out_chan
);

  ubi_pkg::row_job_t job;
  logic              advance;

  ubi_row_seq u_row_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .advance (advance),
    .job     (job)
  );

  ubi_row_pipe u_row_pipe (
    .clk      (clk),
    .rst_n    (rst_n),
    .job      (job),
    .advance  (advance),
    .out_chan (out_chan)
  );

endmodule
